// ===== rtl/core/ccl_pkg.sv =====
// Shared types and constants for the chunk cache LRU lookup core.
// Holds field widths, chunk geometry, register indexes, controller states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package ccl_pkg;

	localparam int COORD_BITS  = 16;
	localparam int CHUNK_EDGE  = 128;
	localparam int LOCAL_BITS  = $clog2(CHUNK_EDGE);
	localparam int BASE_BITS   = 16;
	localparam int FETCH_BITS  = 17;
	localparam int SLOT_BITS   = 3;
	localparam int STAMP_BITS  = 64;
	localparam int DEF_WAYS    = 8;

	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [COORD_BITS-1:0] OFS_MASK = COORD_BITS'(CHUNK_EDGE - 1);

	localparam logic [BASE_BITS-1:0] BASE_Z_RST = BASE_BITS'(5120);
	localparam logic [BASE_BITS-1:0] BASE_Y_RST = BASE_BITS'(2048);
	localparam logic [BASE_BITS-1:0] BASE_X_RST = BASE_BITS'(3200);

	typedef enum logic [1:0] {
		REG_BASE_Z,
		REG_BASE_Y,
		REG_BASE_X
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_FILL,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic look;
		logic scan_step;
		logic fill;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic same;
		logic hit;
		logic has_empty;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ccl_regs.sv =====
// Configuration register file for the chunk cache lookup core.
// APB-style write and read of the three volume base registers; uses ccl_pkg.
`default_nettype none

module ccl_regs
	import ccl_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0] paddr,
	input  wire logic [CFG_DATA_BITS-1:0] pwdata,
	output logic      [CFG_DATA_BITS-1:0] prdata,
	output logic                          pready,
	output logic      [BASE_BITS-1:0]     base_z,
	output logic      [BASE_BITS-1:0]     base_y,
	output logic      [BASE_BITS-1:0]     base_x
);

	logic [BASE_BITS-1:0] base_z_q, base_y_q, base_x_q;
	reg_idx_t             idx;
	logic                 wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_z_q <= BASE_Z_RST;
			base_y_q <= BASE_Y_RST;
			base_x_q <= BASE_X_RST;
		end else if (wr_en) begin
			case (idx)
				REG_BASE_Z: base_z_q <= pwdata[BASE_BITS-1:0];
				REG_BASE_Y: base_y_q <= pwdata[BASE_BITS-1:0];
				REG_BASE_X: base_x_q <= pwdata[BASE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_BASE_Z: prdata = CFG_DATA_BITS'(base_z_q);
			REG_BASE_Y: prdata = CFG_DATA_BITS'(base_y_q);
			REG_BASE_X: prdata = CFG_DATA_BITS'(base_x_q);
			default:    prdata = '0;
		endcase
	end

	assign base_z = base_z_q;
	assign base_y = base_y_q;
	assign base_x = base_x_q;

endmodule

`default_nettype wire

// ===== rtl/core/ccl_ctrl.sv =====
// Controller state machine for the chunk cache lookup core.
// Sequences capture, lookup, victim scan, fill and result hand-off; uses ccl_pkg.
`default_nettype none

module ccl_ctrl
	import ccl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire dp_status_t stat,
	output ctrl_cmd_t       cmd
);

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (stat.same || stat.hit || stat.has_empty) begin
					state_nxt = ST_DONE;
				end else begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_nxt = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill  = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/ccl_dp.sv =====
// Datapath for the chunk cache lookup core: tag store, stamps, use counter,
// current-chunk shortcut, LRU victim scan and output register; uses ccl_pkg.
`default_nettype none

module ccl_dp
	import ccl_pkg::*;
#(
	parameter int WAYS = DEF_WAYS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_cmd_t             cmd,
	output dp_status_t                 stat,
	input  wire logic [COORD_BITS-1:0] voxel_z,
	input  wire logic [COORD_BITS-1:0] voxel_y,
	input  wire logic [COORD_BITS-1:0] voxel_x,
	input  wire logic [BASE_BITS-1:0]  base_z,
	input  wire logic [BASE_BITS-1:0]  base_y,
	input  wire logic [BASE_BITS-1:0]  base_x,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       same_chunk,
	output logic                       hit,
	output logic      [SLOT_BITS-1:0]  slot,
	output logic                       fetch,
	output logic                       evict,
	output logic      [FETCH_BITS-1:0] fetch_z,
	output logic      [FETCH_BITS-1:0] fetch_y,
	output logic      [FETCH_BITS-1:0] fetch_x,
	output logic      [LOCAL_BITS-1:0] local_z,
	output logic      [LOCAL_BITS-1:0] local_y,
	output logic      [LOCAL_BITS-1:0] local_x
);

	localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

	// tag store
	logic                  valid_q [WAYS];
	logic [COORD_BITS-1:0] tag_z_q [WAYS];
	logic [COORD_BITS-1:0] tag_y_q [WAYS];
	logic [COORD_BITS-1:0] tag_x_q [WAYS];
	logic [STAMP_BITS-1:0] stamp_q [WAYS];
	logic [STAMP_BITS-1:0] ctr_q;

	logic                  cur_valid_q;
	logic [WAY_BITS-1:0]   cur_slot_q;
	logic [COORD_BITS-1:0] cur_z_q, cur_y_q, cur_x_q;

	logic [COORD_BITS-1:0] org_z_q, org_y_q, org_x_q;
	logic [LOCAL_BITS-1:0] loc_z_q, loc_y_q, loc_x_q;

	logic [WAY_BITS-1:0]   scan_idx_q;
	logic [WAY_BITS-1:0]   victim_q;
	logic [STAMP_BITS-1:0] oldest_q;

	logic                  res_same_q, res_hit_q, res_fetch_q, res_evict_q;
	logic [WAY_BITS-1:0]   res_slot_q;

	logic                  out_valid_q;
	logic                  out_same_q, out_hit_q, out_fetch_q, out_evict_q;
	logic [SLOT_BITS-1:0]  out_slot_q;
	logic [FETCH_BITS-1:0] out_fz_q, out_fy_q, out_fx_q;
	logic [LOCAL_BITS-1:0] out_lz_q, out_ly_q, out_lx_q;

	logic                  same;
	logic                  hit_any, empty_any;
	logic [WAY_BITS-1:0]   hit_way, empty_way, fill_way;
	logic                  do_fill;

	always_comb begin
		hit_any   = 1'b0;
		hit_way   = '0;
		empty_any = 1'b0;
		empty_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_z_q[i] == org_z_q && tag_y_q[i] == org_y_q &&
			    tag_x_q[i] == org_x_q) begin
				hit_any = 1'b1;
				hit_way = WAY_BITS'(i);
			end
			if (!valid_q[i]) begin
				empty_any = 1'b1;
				empty_way = WAY_BITS'(i);
			end
		end
	end

	assign same = cur_valid_q && cur_z_q == org_z_q && cur_y_q == org_y_q &&
	              cur_x_q == org_x_q;

	assign do_fill  = (cmd.look && !same && !hit_any && empty_any) || cmd.fill;
	assign fill_way = cmd.fill ? victim_q : empty_way;

	assign stat.same      = same;
	assign stat.hit       = hit_any;
	assign stat.has_empty = empty_any;
	assign stat.scan_last = scan_idx_q == WAY_BITS'(WAYS - 1);
	assign stat.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WAYS; i++) begin
				valid_q[i] <= 1'b0;
			end
			ctr_q       <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.look && !same && hit_any) begin
				ctr_q       <= ctr_q + STAMP_BITS'(1);
				cur_valid_q <= 1'b1;
				cur_slot_q  <= hit_way;
			end else if (do_fill) begin
				valid_q[fill_way] <= 1'b1;
				ctr_q             <= ctr_q + STAMP_BITS'(1);
				cur_valid_q       <= 1'b1;
				cur_slot_q        <= fill_way;
			end
			if (cmd.look) begin
				scan_idx_q <= WAY_BITS'(1);
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + WAY_BITS'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			org_z_q <= voxel_z & ~OFS_MASK;
			org_y_q <= voxel_y & ~OFS_MASK;
			org_x_q <= voxel_x & ~OFS_MASK;
			loc_z_q <= voxel_z[LOCAL_BITS-1:0];
			loc_y_q <= voxel_y[LOCAL_BITS-1:0];
			loc_x_q <= voxel_x[LOCAL_BITS-1:0];
		end
		if (cmd.look) begin
			res_same_q  <= same;
			res_hit_q   <= same || hit_any;
			res_fetch_q <= !same && !hit_any;
			res_evict_q <= 1'b0;
			if (same) begin
				res_slot_q <= cur_slot_q;
			end else if (hit_any) begin
				res_slot_q       <= hit_way;
				stamp_q[hit_way] <= ctr_q;
			end else begin
				res_slot_q <= empty_way;
			end
			oldest_q <= stamp_q[0];
			victim_q <= '0;
		end
		if (cmd.scan_step && stamp_q[scan_idx_q] < oldest_q) begin
			oldest_q <= stamp_q[scan_idx_q];
			victim_q <= scan_idx_q;
		end
		if (cmd.fill) begin
			res_slot_q  <= victim_q;
			res_evict_q <= 1'b1;
		end
		if (do_fill) begin
			tag_z_q[fill_way] <= org_z_q;
			tag_y_q[fill_way] <= org_y_q;
			tag_x_q[fill_way] <= org_x_q;
			stamp_q[fill_way] <= ctr_q;
		end
		if (cmd.look && !same) begin
			cur_z_q <= org_z_q;
			cur_y_q <= org_y_q;
			cur_x_q <= org_x_q;
		end
		if (cmd.load_out) begin
			out_same_q  <= res_same_q;
			out_hit_q   <= res_hit_q;
			out_fetch_q <= res_fetch_q;
			out_evict_q <= res_evict_q;
			out_slot_q  <= SLOT_BITS'(res_slot_q);
			out_lz_q    <= loc_z_q;
			out_ly_q    <= loc_y_q;
			out_lx_q    <= loc_x_q;
			if (res_fetch_q) begin
				out_fz_q <= FETCH_BITS'(org_z_q) + FETCH_BITS'(base_z);
				out_fy_q <= FETCH_BITS'(org_y_q) + FETCH_BITS'(base_y);
				out_fx_q <= FETCH_BITS'(org_x_q) + FETCH_BITS'(base_x);
			end else begin
				out_fz_q <= '0;
				out_fy_q <= '0;
				out_fx_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign same_chunk = out_same_q;
	assign hit        = out_hit_q;
	assign slot       = out_slot_q;
	assign fetch      = out_fetch_q;
	assign evict      = out_evict_q;
	assign fetch_z    = out_fz_q;
	assign fetch_y    = out_fy_q;
	assign fetch_x    = out_fx_q;
	assign local_z    = out_lz_q;
	assign local_y    = out_ly_q;
	assign local_x    = out_lx_q;

endmodule

`default_nettype wire

// ===== rtl/core/chunk_cache_lru_lookup_core.sv =====
// Chunk cache LRU lookup core: top level joining registers, controller, datapath.
// Sequence: capture, lookup, then result load for same-chunk, hit or empty-way fill;
// on a miss with every way valid, a victim scan (one stamp compared per cycle) and
// a fill come between; a new item is taken only once the last result is loaded out.
// Reset (arst_n low): all ways invalid, use counter and current chunk cleared,
// base registers to 5120/2048/3200; no clearing pass.
`default_nettype none

module chunk_cache_lru_lookup_core
	import ccl_pkg::*;
#(
	parameter int WAYS = DEF_WAYS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0] paddr,
	input  wire logic [CFG_DATA_BITS-1:0] pwdata,
	output logic      [CFG_DATA_BITS-1:0] prdata,
	output logic                          pready,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [COORD_BITS-1:0]    voxel_z,
	input  wire logic [COORD_BITS-1:0]    voxel_y,
	input  wire logic [COORD_BITS-1:0]    voxel_x,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          same_chunk,
	output logic                          hit,
	output logic      [SLOT_BITS-1:0]     slot,
	output logic                          fetch,
	output logic                          evict,
	output logic      [FETCH_BITS-1:0]    fetch_z,
	output logic      [FETCH_BITS-1:0]    fetch_y,
	output logic      [FETCH_BITS-1:0]    fetch_x,
	output logic      [LOCAL_BITS-1:0]    local_z,
	output logic      [LOCAL_BITS-1:0]    local_y,
	output logic      [LOCAL_BITS-1:0]    local_x
);

	logic [BASE_BITS-1:0] base_z, base_y, base_x;
	ctrl_cmd_t            cmd;
	dp_status_t           stat;

	ccl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.base_z  (base_z),
		.base_y  (base_y),
		.base_x  (base_x)
	);

	ccl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ccl_dp #(
		.WAYS (WAYS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.voxel_z    (voxel_z),
		.voxel_y    (voxel_y),
		.voxel_x    (voxel_x),
		.base_z     (base_z),
		.base_y     (base_y),
		.base_x     (base_x),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.same_chunk (same_chunk),
		.hit        (hit),
		.slot       (slot),
		.fetch      (fetch),
		.evict      (evict),
		.fetch_z    (fetch_z),
		.fetch_y    (fetch_y),
		.fetch_x    (fetch_x),
		.local_z    (local_z),
		.local_y    (local_y),
		.local_x    (local_x)
	);

endmodule

`default_nettype wire

// ===== tb/tb_chunk_cache_lru_lookup_core.sv =====
// Self-checking testbench for chunk_cache_lru_lookup_core: streams voxel beats through
// the core and checks every result against an in-bench LRU cache predictor.
// Depends on ccl_pkg and the core RTL only.
`default_nettype none

module tb_chunk_cache_lru_lookup_core
	import ccl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [COORD_BITS-1:0] z;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] x;
	} voxel_t;

	typedef struct packed {
		logic                  same_chunk;
		logic                  hit;
		logic [SLOT_BITS-1:0]  slot;
		logic                  fetch;
		logic                  evict;
		logic [FETCH_BITS-1:0] fetch_z;
		logic [FETCH_BITS-1:0] fetch_y;
		logic [FETCH_BITS-1:0] fetch_x;
		logic [LOCAL_BITS-1:0] local_z;
		logic [LOCAL_BITS-1:0] local_y;
		logic [LOCAL_BITS-1:0] local_x;
	} lookup_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr = '0;
	logic [CFG_DATA_BITS-1:0] pwdata = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [COORD_BITS-1:0]    voxel_z = '0;
	logic [COORD_BITS-1:0]    voxel_y = '0;
	logic [COORD_BITS-1:0]    voxel_x = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     same_chunk;
	logic                     hit;
	logic [SLOT_BITS-1:0]     slot;
	logic                     fetch;
	logic                     evict;
	logic [FETCH_BITS-1:0]    fetch_z;
	logic [FETCH_BITS-1:0]    fetch_y;
	logic [FETCH_BITS-1:0]    fetch_x;
	logic [LOCAL_BITS-1:0]    local_z;
	logic [LOCAL_BITS-1:0]    local_y;
	logic [LOCAL_BITS-1:0]    local_x;

	voxel_t      voxel_queue[$];
	lookup_res_t predicted_lookups[$];
	voxel_t      drv_voxel;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;

	logic [BASE_BITS-1:0]  cfg_base_z = BASE_Z_RST;
	logic [BASE_BITS-1:0]  cfg_base_y = BASE_Y_RST;
	logic [BASE_BITS-1:0]  cfg_base_x = BASE_X_RST;
	logic                  tag_valid[DEF_WAYS] = '{default: 1'b0};
	voxel_t                tag_org[DEF_WAYS];
	logic [STAMP_BITS-1:0] tag_age[DEF_WAYS];
	logic [STAMP_BITS-1:0] age_clock = '0;
	logic                  cur_hold = 1'b0;
	logic [SLOT_BITS-1:0]  cur_way = '0;
	voxel_t                cur_org = '0;

	chunk_cache_lru_lookup_core #(.WAYS(DEF_WAYS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.voxel_z(voxel_z), .voxel_y(voxel_y), .voxel_x(voxel_x),
		.out_valid(out_valid), .out_stall(out_stall),
		.same_chunk(same_chunk), .hit(hit), .slot(slot), .fetch(fetch), .evict(evict),
		.fetch_z(fetch_z), .fetch_y(fetch_y), .fetch_x(fetch_x),
		.local_z(local_z), .local_y(local_y), .local_x(local_x)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic lookup_res_t resolve_chunk(voxel_t v);
		lookup_res_t r;
		voxel_t      org;
		int          w;
		bit          found;
		r = '0;
		r.local_z = LOCAL_BITS'(v.z % CHUNK_EDGE);
		r.local_y = LOCAL_BITS'(v.y % CHUNK_EDGE);
		r.local_x = LOCAL_BITS'(v.x % CHUNK_EDGE);
		org.z = v.z - COORD_BITS'(r.local_z);
		org.y = v.y - COORD_BITS'(r.local_y);
		org.x = v.x - COORD_BITS'(r.local_x);
		if (cur_hold && cur_org == org) begin
			r.same_chunk = 1'b1;
			r.hit = 1'b1;
			r.slot = cur_way;
			return r;
		end
		found = 1'b0;
		w = 0;
		for (int i = 0; i < DEF_WAYS; i++)
			if (!found && tag_valid[i] && tag_org[i] == org) begin
				found = 1'b1;
				w = i;
			end
		if (found) begin
			r.hit = 1'b1;
		end else begin
			w = DEF_WAYS;
			for (int i = DEF_WAYS - 1; i >= 0; i--)
				if (!tag_valid[i])
					w = i;
			if (w == DEF_WAYS) begin
				// oldest stamp goes, lowest way on a tie
				w = 0;
				for (int i = 1; i < DEF_WAYS; i++)
					if (tag_age[i] < tag_age[w])
						w = i;
				r.evict = 1'b1;
			end
			tag_valid[w] = 1'b1;
			tag_org[w] = org;
			r.fetch = 1'b1;
			r.fetch_z = FETCH_BITS'(org.z) + FETCH_BITS'(cfg_base_z);
			r.fetch_y = FETCH_BITS'(org.y) + FETCH_BITS'(cfg_base_y);
			r.fetch_x = FETCH_BITS'(org.x) + FETCH_BITS'(cfg_base_x);
		end
		tag_age[w] = age_clock;
		age_clock = age_clock + 1'b1;
		cur_hold = 1'b1;
		cur_way = SLOT_BITS'(w);
		cur_org = org;
		r.slot = SLOT_BITS'(w);
		return r;
	endfunction

	function automatic string fmt_res(lookup_res_t r);
		return $sformatf("same=%0d hit=%0d slot=%0d fetch=%0d evict=%0d f=(%0d,%0d,%0d) l=(%0d,%0d,%0d)",
			r.same_chunk, r.hit, r.slot, r.fetch, r.evict, r.fetch_z, r.fetch_y, r.fetch_x,
			r.local_z, r.local_y, r.local_x);
	endfunction

	task automatic check_result();
		lookup_res_t got;
		lookup_res_t want;
		got.same_chunk = same_chunk;
		got.hit = hit;
		got.slot = slot;
		got.fetch = fetch;
		got.evict = evict;
		got.fetch_z = fetch_z;
		got.fetch_y = fetch_y;
		got.fetch_x = fetch_x;
		got.local_z = local_z;
		got.local_y = local_y;
		got.local_x = local_x;
		if (predicted_lookups.size() == 0) begin
			if (mismatch_cnt < 10)
				$display("unexpected result beat: %s", fmt_res(got));
			mismatch_cnt++;
		end else begin
			want = predicted_lookups.pop_front();
			if (got !== want) begin
				if (mismatch_cnt < 10)
					$display("mismatch: exp %s | act %s", fmt_res(want), fmt_res(got));
				mismatch_cnt++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predicted_lookups.push_back(resolve_chunk(drv_voxel));
			if (!in_valid || !in_stall) begin
				if (voxel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drv_voxel = voxel_queue.pop_front();
					in_valid <= 1'b1;
					voxel_z <= drv_voxel.z;
					voxel_y <= drv_voxel.y;
					voxel_x <= drv_voxel.x;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_chunk_cache_lru_lookup_core failed");
			$finish;
		end
	end

	task automatic write_base(reg_idx_t idx, logic [BASE_BITS-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_BITS'(4 * int'(idx));
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BASE_Z: cfg_base_z = val;
			REG_BASE_Y: cfg_base_y = val;
			default:    cfg_base_x = val;
		endcase
	endtask

	task automatic drain();
		do @(negedge clk);
		while (voxel_queue.size() != 0 || in_valid || predicted_lookups.size() != 0);
	endtask

	task automatic add_random(int n);
		voxel_t pool[16];
		voxel_t last;
		voxel_t v;
		int     pool_n;
		int     r;
		pool_n = $urandom_range(2, 14);
		for (int i = 0; i < pool_n; i++) begin
			pool[i].z = 16'($urandom) & ~OFS_MASK;
			pool[i].y = 16'($urandom) & ~OFS_MASK;
			pool[i].x = 16'($urandom) & ~OFS_MASK;
			// neighbors that differ on a single axis
			if (i > 0 && $urandom_range(0, 9) < 3) begin
				r = $urandom_range(0, 2);
				if (r != 0) pool[i].z = pool[i-1].z;
				if (r != 1) pool[i].y = pool[i-1].y;
				if (r != 2) pool[i].x = pool[i-1].x;
			end
		end
		last = pool[0];
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				v.z = 16'($urandom);
				v.y = 16'($urandom);
				v.x = 16'($urandom);
			end else begin
				if (r >= 35)
					last = pool[$urandom_range(0, pool_n - 1)];
				v.z = (last.z & ~OFS_MASK) | (16'($urandom) & OFS_MASK);
				v.y = (last.y & ~OFS_MASK) | (16'($urandom) & OFS_MASK);
				v.x = (last.x & ~OFS_MASK) | (16'($urandom) & OFS_MASK);
			end
			last = v;
			voxel_queue.push_back(v);
		end
	endtask

	initial begin
		logic [BASE_BITS-1:0] bz, by, bx;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		voxel_queue.push_back('{16'd0, 16'd0, 16'd0});
		voxel_queue.push_back('{16'd127, 16'd127, 16'd127});
		voxel_queue.push_back('{16'd65535, 16'd65535, 16'd65535});
		voxel_queue.push_back('{16'd0, 16'd0, 16'd5});
		voxel_queue.push_back('{16'd128, 16'd0, 16'd0});
		voxel_queue.push_back('{16'd0, 16'd128, 16'd0});
		voxel_queue.push_back('{16'd0, 16'd0, 16'd128});
		voxel_queue.push_back('{16'd65535, 16'd0, 16'd0});
		voxel_queue.push_back('{16'd0, 16'd65535, 16'd0});
		voxel_queue.push_back('{16'd0, 16'd0, 16'd65535});
		voxel_queue.push_back('{16'd256, 16'd256, 16'd256});
		voxel_queue.push_back('{16'd65535, 16'd65535, 16'd65535});
		voxel_queue.push_back('{16'd256, 16'd256, 16'd384});
		voxel_queue.push_back('{16'd300, 16'd383, 16'd511});
		voxel_queue.push_back('{16'd127, 16'd0, 16'd0});
		voxel_queue.push_back('{16'd65408, 16'd65408, 16'd65408});
		voxel_queue.push_back('{16'd12345, 16'd54321, 16'd43210});
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 7; stall_pct = 7; end
			endcase
			if (ph == 0) begin
				bz = '0; by = '0; bx = '0;
			end else if (ph == 1) begin
				bz = '1; by = '1; bx = '1;
			end else if (ph == 2) begin
				bz = '0; by = '1; bx = BASE_BITS'($urandom);
			end else begin
				bz = BASE_BITS'($urandom); by = BASE_BITS'($urandom); bx = BASE_BITS'($urandom);
			end
			write_base(REG_BASE_Z, bz);
			write_base(REG_BASE_Y, by);
			write_base(REG_BASE_X, bx);
			add_random(110);
			drain();
			add_random(110);
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && predicted_lookups.size() == 0)
			$display("tb_chunk_cache_lru_lookup_core passed");
		else
			$display("tb_chunk_cache_lru_lookup_core failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/ccl_pkg.sv
rtl/core/ccl_regs.sv
rtl/core/ccl_ctrl.sv
rtl/core/ccl_dp.sv
rtl/core/chunk_cache_lru_lookup_core.sv
tb/tb_chunk_cache_lru_lookup_core.sv
